@@ rtl/sli_pkg.sv @@
// Shared types, microcode fields and the control program of the sorted list block.
package sli_pkg;

    localparam int UPC_W = 5;

    // Result status codes.
    typedef enum logic [2:0] {
        ST_INSERTED  = 3'd0,
        ST_FULL      = 3'd1,
        ST_DELETED   = 3'd2,
        ST_NOT_FOUND = 3'd3,
        ST_EMPTY     = 3'd4
    } status_t;

    typedef enum logic [0:0] {
        ACT_INSERT = 1'b0,
        ACT_DELETE = 1'b1
    } action_t;

    typedef struct packed {
        logic              action;
        logic signed [7:0] value;
    } cmd_t;

    typedef struct packed {
        logic [2:0]        status;
        logic [4:0]        entry_count;
        logic signed [7:0] smallest_value;
    } result_t;

    // Jump conditions evaluated by the sequencer.
    typedef enum logic [3:0] {
        COND_NEXT,
        COND_ALWAYS,
        COND_ACT,
        COND_FULL,
        COND_EMPTY,
        COND_POS_EQ_CNT,
        COND_VAL_LE_RD,
        COND_K_EQ_POS,
        COND_RD_EQ_VAL,
        COND_K1_EQ_CNT
    } cond_t;

    typedef enum logic [1:0] {
        ADDR_POS,
        ADDR_K_DN,
        ADDR_K_UP,
        ADDR_ZERO
    } addr_sel_t;

    typedef enum logic [1:0] {
        WR_NONE,
        WR_K_RDATA,
        WR_POS_VAL
    } wr_sel_t;

    typedef enum logic [0:0] {
        POS_HOLD,
        POS_INC
    } pos_op_t;

    typedef enum logic [2:0] {
        K_HOLD,
        K_LOAD_CNT,
        K_LOAD_POS,
        K_DEC,
        K_INC
    } k_op_t;

    typedef enum logic [1:0] {
        CNT_HOLD,
        CNT_INC,
        CNT_DEC
    } cnt_op_t;

    // One control word of the program.
    typedef struct packed {
        cond_t            cond;
        logic [UPC_W-1:0] target;
        logic             rd_en;
        addr_sel_t        rd_sel;
        wr_sel_t          wr_sel;
        pos_op_t          pos_op;
        k_op_t            k_op;
        cnt_op_t          cnt_op;
        logic             st_load;
        status_t          st_val;
        logic             done;
    } uword_t;

    // Datapath conditions seen by the sequencer.
    typedef struct packed {
        logic act;
        logic full;
        logic empty;
        logic pos_eq_cnt;
        logic val_le_rd;
        logic k_eq_pos;
        logic rd_eq_val;
        logic k1_eq_cnt;
    } flags_t;

    // Program step addresses.
    localparam logic [UPC_W-1:0] U_DISPATCH = 5'd0;
    localparam logic [UPC_W-1:0] U_I_CHECK  = 5'd1;
    localparam logic [UPC_W-1:0] U_I_SCAN   = 5'd2;
    localparam logic [UPC_W-1:0] U_I_CMP    = 5'd3;
    localparam logic [UPC_W-1:0] U_I_STEP   = 5'd4;
    localparam logic [UPC_W-1:0] U_I_OPEN   = 5'd5;
    localparam logic [UPC_W-1:0] U_I_SHIFT  = 5'd6;
    localparam logic [UPC_W-1:0] U_I_MOVE   = 5'd7;
    localparam logic [UPC_W-1:0] U_I_PUT    = 5'd8;
    localparam logic [UPC_W-1:0] U_I_FULL   = 5'd9;
    localparam logic [UPC_W-1:0] U_D_CHECK  = 5'd10;
    localparam logic [UPC_W-1:0] U_D_SCAN   = 5'd11;
    localparam logic [UPC_W-1:0] U_D_CMP    = 5'd12;
    localparam logic [UPC_W-1:0] U_D_STEP   = 5'd13;
    localparam logic [UPC_W-1:0] U_D_CLOSE  = 5'd14;
    localparam logic [UPC_W-1:0] U_D_SHIFT  = 5'd15;
    localparam logic [UPC_W-1:0] U_D_MOVE   = 5'd16;
    localparam logic [UPC_W-1:0] U_D_DROP   = 5'd17;
    localparam logic [UPC_W-1:0] U_D_MISS   = 5'd18;
    localparam logic [UPC_W-1:0] U_D_EMPTY  = 5'd19;
    localparam logic [UPC_W-1:0] U_FETCH    = 5'd20;
    localparam logic [UPC_W-1:0] U_REPORT   = 5'd21;

    // Control store. Unused addresses hold a word that only sets done.
    function automatic uword_t ucode_rom(input logic [UPC_W-1:0] addr);
        uword_t w;
        w = '0;
        unique case (addr)
            U_DISPATCH: begin
                w.cond   = COND_ACT;
                w.target = U_D_CHECK;
            end
            U_I_CHECK: begin
                w.cond   = COND_FULL;
                w.target = U_I_FULL;
            end
            U_I_SCAN: begin
                w.cond   = COND_POS_EQ_CNT;
                w.target = U_I_OPEN;
                w.rd_en  = 1'b1;
                w.rd_sel = ADDR_POS;
            end
            U_I_CMP: begin
                w.cond   = COND_VAL_LE_RD;
                w.target = U_I_OPEN;
            end
            U_I_STEP: begin
                w.cond   = COND_ALWAYS;
                w.target = U_I_SCAN;
                w.pos_op = POS_INC;
            end
            U_I_OPEN: begin
                w.k_op = K_LOAD_CNT;
            end
            U_I_SHIFT: begin
                w.cond   = COND_K_EQ_POS;
                w.target = U_I_PUT;
                w.rd_en  = 1'b1;
                w.rd_sel = ADDR_K_DN;
            end
            U_I_MOVE: begin
                w.cond   = COND_ALWAYS;
                w.target = U_I_SHIFT;
                w.wr_sel = WR_K_RDATA;
                w.k_op   = K_DEC;
            end
            U_I_PUT: begin
                w.cond    = COND_ALWAYS;
                w.target  = U_FETCH;
                w.wr_sel  = WR_POS_VAL;
                w.cnt_op  = CNT_INC;
                w.st_load = 1'b1;
                w.st_val  = ST_INSERTED;
            end
            U_I_FULL: begin
                w.cond    = COND_ALWAYS;
                w.target  = U_FETCH;
                w.st_load = 1'b1;
                w.st_val  = ST_FULL;
            end
            U_D_CHECK: begin
                w.cond   = COND_EMPTY;
                w.target = U_D_EMPTY;
            end
            U_D_SCAN: begin
                w.cond   = COND_POS_EQ_CNT;
                w.target = U_D_MISS;
                w.rd_en  = 1'b1;
                w.rd_sel = ADDR_POS;
            end
            U_D_CMP: begin
                w.cond   = COND_RD_EQ_VAL;
                w.target = U_D_CLOSE;
            end
            U_D_STEP: begin
                w.cond   = COND_ALWAYS;
                w.target = U_D_SCAN;
                w.pos_op = POS_INC;
            end
            U_D_CLOSE: begin
                w.k_op = K_LOAD_POS;
            end
            U_D_SHIFT: begin
                w.cond   = COND_K1_EQ_CNT;
                w.target = U_D_DROP;
                w.rd_en  = 1'b1;
                w.rd_sel = ADDR_K_UP;
            end
            U_D_MOVE: begin
                w.cond   = COND_ALWAYS;
                w.target = U_D_SHIFT;
                w.wr_sel = WR_K_RDATA;
                w.k_op   = K_INC;
            end
            U_D_DROP: begin
                w.cond    = COND_ALWAYS;
                w.target  = U_FETCH;
                w.cnt_op  = CNT_DEC;
                w.st_load = 1'b1;
                w.st_val  = ST_DELETED;
            end
            U_D_MISS: begin
                w.cond    = COND_ALWAYS;
                w.target  = U_FETCH;
                w.st_load = 1'b1;
                w.st_val  = ST_NOT_FOUND;
            end
            U_D_EMPTY: begin
                w.cond    = COND_ALWAYS;
                w.target  = U_FETCH;
                w.st_load = 1'b1;
                w.st_val  = ST_EMPTY;
            end
            U_FETCH: begin
                w.rd_en  = 1'b1;
                w.rd_sel = ADDR_ZERO;
            end
            U_REPORT: begin
                w.done = 1'b1;
            end
            default: begin
                w.done = 1'b1;
            end
        endcase
        return w;
    endfunction

endpackage

@@ rtl/sli_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
module sli_ram
    #(
        parameter int WIDTH = 8,
        parameter int DEPTH = 16
    )
    (
        input  logic                     clk,
        input  logic                     we,
        input  logic [$clog2(DEPTH)-1:0] waddr,
        input  logic [WIDTH-1:0]         wdata,
        input  logic                     re,
        input  logic [$clog2(DEPTH)-1:0] raddr,
        output logic [WIDTH-1:0]         rdata
    );

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ rtl/sli_sequencer.sv @@
// Microprogram sequencer: step counter, control store lookup and conditional jumps.
module sli_sequencer
    import sli_pkg::*;
    (
        input  logic   clk,
        input  logic   rst_n,
        input  logic   launch,
        input  flags_t flags,
        output uword_t uw,
        output logic   running
    );

    logic [UPC_W-1:0] upc_reg;
    logic [UPC_W-1:0] upc_next;
    logic             run_reg;
    logic             run_next;
    logic             taken;

    assign uw      = run_reg ? ucode_rom(upc_reg) : '0;
    assign running = run_reg;

    always_comb
    begin
        unique case (uw.cond)
            COND_NEXT:       taken = 1'b0;
            COND_ALWAYS:     taken = 1'b1;
            COND_ACT:        taken = flags.act;
            COND_FULL:       taken = flags.full;
            COND_EMPTY:      taken = flags.empty;
            COND_POS_EQ_CNT: taken = flags.pos_eq_cnt;
            COND_VAL_LE_RD:  taken = flags.val_le_rd;
            COND_K_EQ_POS:   taken = flags.k_eq_pos;
            COND_RD_EQ_VAL:  taken = flags.rd_eq_val;
            COND_K1_EQ_CNT:  taken = flags.k1_eq_cnt;
            default:         taken = 1'b0;
        endcase
    end

    always_comb
    begin
        upc_next = upc_reg;
        run_next = run_reg;
        priority if (launch)
        begin
            upc_next = U_DISPATCH;
            run_next = 1'b1;
        end
        else if (run_reg)
        begin
            upc_next = taken ? uw.target : upc_reg + UPC_W'(1);
            if (uw.done)
            begin
                run_next = 1'b0;
            end
        end
        else
        begin
            upc_next = upc_reg;
            run_next = run_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            upc_reg <= '0;
            run_reg <= 1'b0;
        end
        else
        begin
            upc_reg <= upc_next;
            run_reg <= run_next;
        end
    end

endmodule

@@ rtl/sli_datapath.sv @@
// Datapath of the sorted list: entry memory, pointers, count and result register.
module sli_datapath
    import sli_pkg::*;
    #(
        parameter int CAPACITY = 16
    )
    (
        input  logic    clk,
        input  logic    rst_n,
        input  logic    launch,
        input  cmd_t    cmd,
        input  uword_t  uw,
        output flags_t  flags,
        output logic    done,
        output result_t result
    );

    localparam int CW = $clog2(CAPACITY + 1);
    localparam int IW = $clog2(CAPACITY);
    localparam int XW = CW + 5;

    logic signed [7:0] val_reg;
    logic              act_reg;
    logic [CW-1:0]     pos_reg;
    logic [CW-1:0]     pos_next;
    logic [CW-1:0]     k_reg;
    logic [CW-1:0]     k_next;
    logic [CW-1:0]     cnt_reg;
    logic [CW-1:0]     cnt_next;
    status_t           status_reg;
    logic              done_reg;
    result_t           result_reg;

    logic [CW-1:0]     k_dn;
    logic [CW-1:0]     k_up;
    logic [XW-1:0]     cnt_ext;
    logic [IW-1:0]     raddr;
    logic [IW-1:0]     waddr;
    logic [7:0]        wdata;
    logic              we;
    logic [7:0]        rdata;
    logic signed [7:0] rdata_s;

    assign k_dn    = k_reg - CW'(1);
    assign k_up    = k_reg + CW'(1);
    assign cnt_ext = XW'(cnt_reg);
    assign rdata_s = $signed(rdata);

    always_comb
    begin
        unique case (uw.rd_sel)
            ADDR_POS:  raddr = pos_reg[IW-1:0];
            ADDR_K_DN: raddr = k_dn[IW-1:0];
            ADDR_K_UP: raddr = k_up[IW-1:0];
            ADDR_ZERO: raddr = '0;
            default:   raddr = '0;
        endcase
    end

    always_comb
    begin
        we    = 1'b0;
        waddr = k_reg[IW-1:0];
        wdata = rdata;
        unique case (uw.wr_sel)
            WR_NONE:    we = 1'b0;
            WR_K_RDATA: we = 1'b1;
            WR_POS_VAL:
            begin
                we    = 1'b1;
                waddr = pos_reg[IW-1:0];
                wdata = val_reg;
            end
            default:    we = 1'b0;
        endcase
    end

    sli_ram
        #(
            .WIDTH (8),
            .DEPTH (CAPACITY)
        )
        u_ram
        (
            .clk   (clk),
            .we    (we),
            .waddr (waddr),
            .wdata (wdata),
            .re    (uw.rd_en),
            .raddr (raddr),
            .rdata (rdata)
        );

    always_comb
    begin
        flags.act        = act_reg;
        flags.full       = (cnt_reg == CW'(CAPACITY));
        flags.empty      = (cnt_reg == '0);
        flags.pos_eq_cnt = (pos_reg == cnt_reg);
        flags.val_le_rd  = !(val_reg > rdata_s);
        flags.k_eq_pos   = (k_reg == pos_reg);
        flags.rd_eq_val  = (rdata_s == val_reg);
        flags.k1_eq_cnt  = (k_up == cnt_reg);
    end

    always_comb
    begin
        pos_next = pos_reg;
        if (launch)
        begin
            pos_next = '0;
        end
        else if (uw.pos_op == POS_INC)
        begin
            pos_next = pos_reg + CW'(1);
        end
    end

    always_comb
    begin
        unique case (uw.k_op)
            K_HOLD:     k_next = k_reg;
            K_LOAD_CNT: k_next = cnt_reg;
            K_LOAD_POS: k_next = pos_reg;
            K_DEC:      k_next = k_dn;
            K_INC:      k_next = k_up;
            default:    k_next = k_reg;
        endcase
    end

    always_comb
    begin
        unique case (uw.cnt_op)
            CNT_HOLD: cnt_next = cnt_reg;
            CNT_INC:  cnt_next = cnt_reg + CW'(1);
            CNT_DEC:  cnt_next = cnt_reg - CW'(1);
            default:  cnt_next = cnt_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            done_reg <= uw.done;
        end
    end

    always_ff @(posedge clk)
    begin
        pos_reg <= pos_next;
        k_reg   <= k_next;
        if (launch)
        begin
            val_reg <= cmd.value;
            act_reg <= cmd.action;
        end
        if (uw.st_load)
        begin
            status_reg <= uw.st_val;
        end
        if (uw.done)
        begin
            result_reg.status         <= status_reg;
            result_reg.entry_count    <= cnt_ext[4:0];
            result_reg.smallest_value <= (cnt_reg == '0) ? 8'sd0 : rdata_s;
        end
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

@@ rtl/sorted_list_insert_delete_top.sv @@
// Sorted byte list with insert and delete, run by a microcoded sequencer.
// The steps taken grow with the entries stored and the entries scanned past, for
// inserts and deletes alike; a full list on insert or an empty one on delete ends early.
// done is registered from the done bit of the last step, so it rises in the cycle after it;
// all loops share one RAM read port and one write port. busy covers every step, start is
// taken again in the cycle of done, and the receiver cannot stall. Reset clears the count.
module sorted_list_insert_delete_top
    import sli_pkg::*;
    #(
        parameter int CAPACITY = 16
    )
    (
        input  logic    clk,
        input  logic    rst_n,
        input  logic    start,
        output logic    busy,
        input  cmd_t    cmd,
        output logic    done,
        output result_t result
    );

    // A transaction is taken when start meets an idle sequencer.
    logic   launch;
    logic   running;
    uword_t uw;
    flags_t flags;

    assign launch = start && !running;
    assign busy   = running;

    // The sequencer steps through the control store and decides jumps from the
    // datapath flags; the datapath executes the decoded control word and captures the command at launch.
    sli_sequencer u_seq
        (
            .clk     (clk),
            .rst_n   (rst_n),
            .launch  (launch),
            .flags   (flags),
            .uw      (uw),
            .running (running)
        );

    // The datapath keeps the entries in RAM, the count, and the scan and shift
    // pointers. Its done register drives done for exactly one cycle.
    // Reset clears the entry count, the sequencer and the strobe; stored bytes stay.
    sli_datapath
        #(
            .CAPACITY (CAPACITY)
        )
        u_dp
        (
            .clk    (clk),
            .rst_n  (rst_n),
            .launch (launch),
            .cmd    (cmd),
            .uw     (uw),
            .flags  (flags),
            .done   (done),
            .result (result)
        );

endmodule

@@ tb/sorted_list_insert_delete_top_tb.sv @@
// Self-checking testbench for the sorted byte list with insert and delete.
module sorted_list_insert_delete_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import sli_pkg::*;

    localparam int LIST_CAP     = 16;
    localparam int MAX_GAP      = 19;
    localparam int RANDOM_ITEMS = 1000;
    // The slowest transaction scans or shifts across the whole list of sixteen
    // entries, and this is enough to let any straggling result show up.
    localparam int DRAIN_CYCLES = 80;
    // Worst case is roughly 1030 transactions, each with the longest idle gap and the
    // slowest busy phase, at a 4 ns clock period: about 330 us; the limit leaves a wide margin above that.
    localparam int TIMEOUT_NS   = 3_000_000;

    logic    clk;
    logic    rst_n;
    logic    start;
    logic    busy;
    cmd_t    cmd;
    logic    done;
    result_t result;

    // Shadow copy of the list contents, kept in ascending signed order.
    logic signed [7:0] mirror_list[$];
    // Results predicted at acceptance, oldest first.
    result_t           pending_results[$];
    int unsigned       error_count;
    // Upper bound of the idle gap drawn before each transaction.
    int unsigned       max_gap;

    sorted_list_insert_delete_top #(
        .CAPACITY (LIST_CAP)
    ) dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .cmd    (cmd),
        .done   (done),
        .result (result)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        #(TIMEOUT_NS);
        $display("sorted_list_insert_delete_top_tb: errors");
        $finish;
    end

    task automatic flag_error(string msg);
        $display("ERROR @%0t: %s", $realtime, msg);
        error_count++;
    endtask

    // Applies one transaction to the shadow list and returns the result the
    // block must give for it. Insert goes in front of the first entry that is
    // not smaller, so equal values land ahead of existing equal entries.
    function automatic result_t apply_list_op(cmd_t c);
        result_t           r;
        logic signed [7:0] v;
        int                pos;
        r   = '0;
        v   = c.value;
        pos = 0;
        if (c.action == ACT_INSERT)
        begin
            if (mirror_list.size() >= LIST_CAP)
            begin
                r.status = ST_FULL;
            end
            else
            begin
                while (pos < mirror_list.size() && v > mirror_list[pos])
                    pos++;
                mirror_list.insert(pos, v);
                r.status = ST_INSERTED;
            end
        end
        else if (mirror_list.size() == 0)
        begin
            r.status = ST_EMPTY;
        end
        else
        begin
            while (pos < mirror_list.size() && mirror_list[pos] != v)
                pos++;
            if (pos >= mirror_list.size())
            begin
                r.status = ST_NOT_FOUND;
            end
            else
            begin
                mirror_list.delete(pos);
                r.status = ST_DELETED;
            end
        end
        r.entry_count    = 5'(mirror_list.size());
        r.smallest_value = (mirror_list.size() > 0) ? mirror_list[0] : 8'sd0;
        return r;
    endfunction

    // Value source for random traffic. Stored values are favored on request so
    // that deletes actually hit; otherwise a spread of arbitrary, small and
    // boundary bytes, with duplicates of stored entries mixed in.
    function automatic logic signed [7:0] pick_value(bit prefer_stored);
        logic signed [7:0] v;
        v = 8'($urandom);
        if (prefer_stored && mirror_list.size() > 0)
            return mirror_list[$urandom_range(mirror_list.size() - 1, 0)];
        case ($urandom_range(3, 0))
            0: v = 8'($urandom);
            1: v = 8'($urandom_range(8, 0) - 4);
            2:
            begin
                case ($urandom_range(6, 0))
                    0: v = -8'sd128;
                    1: v = -8'sd127;
                    2: v = -8'sd1;
                    3: v = 8'sd0;
                    4: v = 8'sd1;
                    5: v = 8'sd126;
                    default: v = 8'sd127;
                endcase
            end
            default:
            begin
                if (mirror_list.size() > 0)
                    v = mirror_list[$urandom_range(mirror_list.size() - 1, 0)];
            end
        endcase
        return v;
    endfunction

    // Sends one transaction. Called at a falling edge and returns at one.
    // With no idle gap start simply stays high, so back-to-back transactions
    // never see start dropped and raised within one time step. During a gap
    // the command bus carries junk that the block must ignore.
    task automatic send_item(action_t act, logic signed [7:0] v);
        cmd_t        c;
        int unsigned gap;
        c.action = act;
        c.value  = v;
        gap      = $urandom_range(max_gap, 0);
        if (gap > 0)
        begin
            start <= 1'b0;
            cmd   <= $bits(cmd_t)'($urandom);
            repeat (gap) @(negedge clk);
        end
        start <= 1'b1;
        cmd   <= c;
        do
            @(posedge clk);
        while (busy);
        pending_results.push_back(apply_list_op(c));
        @(negedge clk);
    endtask

    // Every done pulse must match the oldest prediction field by field.
    always @(posedge clk)
    begin
        result_t want;
        if (rst_n && done)
        begin
            if (pending_results.size() == 0)
            begin
                flag_error($sformatf("unexpected result %p", result));
            end
            else
            begin
                want = pending_results.pop_front();
                if (result.status !== want.status)
                    flag_error($sformatf("status %0d, expected %0d",
                                         result.status, want.status));
                if (result.entry_count !== want.entry_count)
                    flag_error($sformatf("entry_count %0d, expected %0d",
                                         result.entry_count, want.entry_count));
                if (result.smallest_value !== want.smallest_value)
                    flag_error($sformatf("smallest_value %0d, expected %0d",
                                         result.smallest_value, want.smallest_value));
            end
        end
    end

    // Both kinds of delete on a list that was never filled must report empty.
    task automatic test_empty_list();
        send_item(ACT_DELETE, 8'sd0);
        send_item(ACT_DELETE, -8'sd128);
    endtask

    // Boundary bytes, duplicate zeros, removal of zero, a miss, and removal
    // of the largest entry.
    task automatic test_extremes_and_zero();
        send_item(ACT_INSERT, 8'sd127);
        send_item(ACT_INSERT, -8'sd128);
        send_item(ACT_INSERT, 8'sd0);
        send_item(ACT_INSERT, 8'sd0);
        send_item(ACT_INSERT, -8'sd1);
        send_item(ACT_INSERT, 8'sd1);
        send_item(ACT_DELETE, 8'sd0);
        send_item(ACT_DELETE, 8'sd0);
        send_item(ACT_DELETE, 8'sd0);
        send_item(ACT_DELETE, 8'sd127);
    endtask

    // Fills the list to capacity, then tries two more inserts that must be
    // turned away as full, one with the largest and one with the smallest byte value.
    task automatic test_full_list();
        while (mirror_list.size() < LIST_CAP)
            send_item(ACT_INSERT, 8'($urandom_range(200, 0) - 100));
        send_item(ACT_INSERT, 8'sd127);
        send_item(ACT_INSERT, -8'sd128);
    endtask

    // Random traffic in segments. Each segment picks an insert bias, so the
    // count swings between empty and full, and an idle profile that runs
    // from fully back-to-back to the longest gaps.
    task automatic test_random_mix();
        int unsigned insert_pct;
        int          n;
        insert_pct = 50;
        for (n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (n % 40 == 0)
            begin
                case ($urandom_range(2, 0))
                    0: insert_pct = 25;
                    1: insert_pct = 55;
                    default: insert_pct = 85;
                endcase
                case ($urandom_range(2, 0))
                    0: max_gap = 0;
                    1: max_gap = 3;
                    default: max_gap = MAX_GAP;
                endcase
            end
            if ($urandom_range(99, 0) < insert_pct)
                send_item(ACT_INSERT, pick_value(1'b0));
            else
                send_item(ACT_DELETE, pick_value($urandom_range(3, 0) != 0));
        end
    endtask

    initial
    begin
        rst_n       = 1'b0;
        start       = 1'b0;
        cmd         = '0;
        error_count = 0;
        max_gap     = MAX_GAP;
        repeat (5) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_empty_list();
        test_extremes_and_zero();
        test_full_list();
        test_random_mix();

        // All transactions are in; wait out the remaining results.
        start <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (error_count == 0)
            $display("sorted_list_insert_delete_top_tb: clean");
        else
            $display("sorted_list_insert_delete_top_tb: errors");
        $finish;
    end

endmodule

@@ filelist.f @@
rtl/sli_pkg.sv
rtl/sli_ram.sv
rtl/sli_sequencer.sv
rtl/sli_datapath.sv
rtl/sorted_list_insert_delete_top.sv
tb/sorted_list_insert_delete_top_tb.sv
